// ===== src/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 border-truncated median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;

    localparam int NUM_TAPS    = 9;
    localparam int RANK_W      = 4;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_EXTRA,
        CMD_PRELOAD,
        CMD_DRAIN
    } t_cmd_kind;

    typedef enum logic {
        FRONT_TAKE,
        FRONT_SECOND
    } t_front_state;

    // control part of one command between front and back
    typedef struct packed {
        t_cmd_kind  kind;
        logic       emit;
        logic [1:0] col_lo;
        logic       col_hi;
        logic       top;
        logic       bot;
        logic       row_end;
        logic       frame_end;
        logic       run_last;
    } t_cmd_ctl;

endpackage

// ===== src/mf3_in_if.sv =====
// ----------------------------------------------------------------------------
// mf3_in_if
// Input channel: operation code and pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mf3_in_if
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, operation, pixel_value, input ready);
    modport sink   (input valid, operation, pixel_value, output ready);
endinterface

// ===== src/mf3_out_if.sv =====
// ----------------------------------------------------------------------------
// mf3_out_if
// Output channel: median result with row, frame and run markers.
// ----------------------------------------------------------------------------
interface mf3_out_if
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] median_value;
    logic                         row_end;
    logic                         frame_end;
    logic                         run_last;

    modport source (output valid, median_value, row_end, frame_end, run_last, input ready);
    modport sink   (input valid, median_value, row_end, frame_end, run_last, output ready);
endinterface

// ===== src/mf3_front.sv =====
// ----------------------------------------------------------------------------
// mf3_front
// Accepts items, tracks column, row and drain position, issues commands.
// ----------------------------------------------------------------------------
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mf3_in_if.sink                i_px,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd_ctl              o_ctl,
    output logic [AW-1:0]         o_addr,
    output logic [PIXEL_BITS-1:0] o_pixel
);

    logic [WIDTH_REG_W-1:0]  r_img_w;
    logic [HEIGHT_REG_W-1:0] r_img_h;
    t_front_state            r_state, n_state;
    logic [AW-1:0]           r_col, n_col;
    logic [15:0]             r_row, n_row;
    logic [AW-1:0]           r_drain, n_drain;
    t_cmd_ctl                r_sec_ctl, n_sec_ctl;
    logic [AW-1:0]           r_sec_addr, n_sec_addr;

    logic [AW-1:0]           w_last;
    logic [15:0]             h_eff;
    logic                    frame_done;
    logic                    last_col;
    logic                    drain_last;
    logic                    top;
    logic                    px_ready;
    t_cmd_ctl                drn_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RESET;
            r_img_h <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[HEIGHT_REG_W-1:0];
                default:          r_img_h <= r_img_h;
            endcase
        end
    end

    always_comb begin
        if (r_img_w == '0) begin
            w_last = '0;
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = AW'(r_img_w - WIDTH_REG_W'(1));
        end
    end

    assign h_eff      = (r_img_h == '0) ? 16'd1 : r_img_h;
    assign frame_done = r_row >= h_eff;
    assign last_col   = r_col >= w_last;
    assign drain_last = r_drain >= w_last;
    assign top        = r_row >= 16'd2;

    always_comb begin
        drn_ctl           = '0;
        drn_ctl.kind      = CMD_DRAIN;
        drn_ctl.emit      = 1'b1;
        drn_ctl.col_lo    = (r_drain != '0) ? 2'd0 : 2'd1;
        drn_ctl.col_hi    = !drain_last;
        drn_ctl.top       = top;
        drn_ctl.bot       = 1'b0;
        drn_ctl.row_end   = drain_last;
        drn_ctl.frame_end = drain_last;
        drn_ctl.run_last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRONT_TAKE;
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec_ctl  <= n_sec_ctl;
        r_sec_addr <= n_sec_addr;
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_sec_ctl  = r_sec_ctl;
        n_sec_addr = r_sec_addr;
        o_push     = 1'b0;
        o_ctl      = '0;
        o_addr     = '0;
        o_pixel    = '0;
        px_ready   = 1'b0;
        unique case (r_state)
            FRONT_TAKE: begin
                px_ready = !i_full;
                if (i_px.valid && px_ready) begin
                    if (i_px.operation == OP_PIXEL) begin
                        if (!frame_done) begin
                            o_push         = 1'b1;
                            o_ctl.kind     = CMD_PIXEL;
                            o_ctl.emit     = (r_row != '0) && (r_col != '0);
                            o_ctl.col_lo   = (r_col > AW'(1)) ? 2'd0 : 2'd1;
                            o_ctl.col_hi   = 1'b1;
                            o_ctl.top      = top;
                            o_ctl.bot      = 1'b1;
                            o_ctl.run_last = !((r_row != '0) && last_col);
                            o_addr         = r_col;
                            o_pixel        = i_px.pixel_value;
                            // the row's last column also gives the result for itself
                            if ((r_row != '0) && last_col) begin
                                n_sec_ctl          = '0;
                                n_sec_ctl.kind     = CMD_EXTRA;
                                n_sec_ctl.emit     = 1'b1;
                                n_sec_ctl.col_lo   = (r_col != '0) ? 2'd1 : 2'd2;
                                n_sec_ctl.col_hi   = 1'b1;
                                n_sec_ctl.top      = top;
                                n_sec_ctl.bot      = 1'b1;
                                n_sec_ctl.row_end  = 1'b1;
                                n_sec_ctl.run_last = 1'b1;
                                n_sec_addr         = r_col;
                                n_state            = FRONT_SECOND;
                            end
                            if (last_col) begin
                                n_col = '0;
                                n_row = r_row + 16'd1;
                            end else begin
                                n_col = r_col + AW'(1);
                            end
                        end
                    end else if (frame_done) begin
                        o_push = 1'b1;
                        if (r_drain == '0) begin
                            // column 0 is fetched ahead of the first drain column
                            o_ctl.kind = CMD_PRELOAD;
                            o_addr     = '0;
                            n_sec_ctl  = drn_ctl;
                            n_sec_addr = r_drain + AW'(1);
                            n_state    = FRONT_SECOND;
                        end else begin
                            o_ctl  = drn_ctl;
                            o_addr = r_drain + AW'(1);
                        end
                        if (drain_last) begin
                            n_drain = '0;
                            n_col   = '0;
                            n_row   = '0;
                        end else begin
                            n_drain = r_drain + AW'(1);
                        end
                    end
                end
            end
            FRONT_SECOND: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    o_ctl   = r_sec_ctl;
                    o_addr  = r_sec_addr;
                    n_state = FRONT_TAKE;
                end
            end
            default: n_state = FRONT_TAKE;
        endcase
    end

    assign i_px.ready = px_ready;

endmodule

// ===== src/mf3_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// mf3_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mf3_cmd_fifo
    import mf3_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ===== src/mf3_back.sv =====
// ----------------------------------------------------------------------------
// mf3_back
// Line stores, 3x3 and drain windows, rank selection and output register.
// ----------------------------------------------------------------------------
module mf3_back
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_cmd_ctl              i_ctl,
    input  logic [AW-1:0]         i_addr,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_pop,
    mf3_out_if.source             o_res
);

    localparam int PB = PIXEL_BITS;

    logic signed [PB-1:0] r_mem_older [MAX_WIDTH];
    logic signed [PB-1:0] r_mem_prev  [MAX_WIDTH];
    logic signed [PB-1:0] r_rd_older;
    logic signed [PB-1:0] r_rd_prev;

    logic                 r_s1_valid;
    t_cmd_ctl             r_s1_ctl;
    logic [AW-1:0]        r_s1_addr;
    logic signed [PB-1:0] r_s1_pix;

    logic                 r_wb_valid;
    logic [AW-1:0]        r_wb_addr;
    logic signed [PB-1:0] r_wb_older;
    logic signed [PB-1:0] r_wb_prev;

    logic signed [PB-1:0] r_win  [3][3];
    logic signed [PB-1:0] n_win  [3][3];
    logic signed [PB-1:0] r_dwin [2][3];
    logic signed [PB-1:0] n_dwin [2][3];

    logic                 r_s2_valid;
    t_cmd_ctl             r_s2_ctl;
    logic signed [PB-1:0] r_s2_vals [NUM_TAPS];
    logic [NUM_TAPS-1:0]  r_s2_mask;
    logic signed [PB-1:0] n_s2_vals [NUM_TAPS];
    logic [NUM_TAPS-1:0]  n_s2_mask;

    logic                 r_out_valid;
    logic signed [PB-1:0] r_out_med;
    logic                 r_out_row_end;
    logic                 r_out_frame_end;
    logic                 r_out_run_last;
    logic signed [PB-1:0] med;

    logic                 en;
    logic                 s1_write;
    logic                 hit;
    logic signed [PB-1:0] b_older;
    logic signed [PB-1:0] b_prev;

    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en && !i_empty;

    assign s1_write = r_s1_valid && (r_s1_ctl.kind == CMD_PIXEL);
    // forward the most recent store write over a read of the same column
    assign hit      = r_wb_valid && (r_wb_addr == r_s1_addr);
    assign b_older  = hit ? r_wb_older : r_rd_older;
    assign b_prev   = hit ? r_wb_prev  : r_rd_prev;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_older <= r_mem_older[i_addr];
            if (s1_write) begin
                r_mem_older[r_s1_addr] <= b_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_prev <= r_mem_prev[i_addr];
            if (s1_write) begin
                r_mem_prev[r_s1_addr] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= o_pop;
            r_wb_valid  <= r_wb_valid || s1_write;
            r_s2_valid  <= r_s1_valid && r_s1_ctl.emit;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctl  <= i_ctl;
            r_s1_addr <= i_addr;
            r_s1_pix  <= i_pixel;
            if (s1_write) begin
                r_wb_addr  <= r_s1_addr;
                r_wb_older <= b_prev;
                r_wb_prev  <= r_s1_pix;
            end
            r_win     <= n_win;
            r_dwin    <= n_dwin;
            r_s2_ctl  <= r_s1_ctl;
            r_s2_vals <= n_s2_vals;
            r_s2_mask <= n_s2_mask;
            r_out_med       <= med;
            r_out_row_end   <= r_s2_ctl.row_end;
            r_out_frame_end <= r_s2_ctl.frame_end;
            r_out_run_last  <= r_s2_ctl.run_last;
        end
    end

    // window update and tap selection
    always_comb begin
        logic row_ok;
        logic col_ok;
        n_win  = r_win;
        n_dwin = r_dwin;
        if (r_s1_valid && (r_s1_ctl.kind == CMD_PIXEL)) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
            n_win[0][2] = b_older;
            n_win[1][2] = b_prev;
            n_win[2][2] = r_s1_pix;
        end
        if (r_s1_valid && ((r_s1_ctl.kind == CMD_PRELOAD) || (r_s1_ctl.kind == CMD_DRAIN))) begin
            for (int r = 0; r < 2; r++) begin
                n_dwin[r][0] = r_dwin[r][1];
                n_dwin[r][1] = r_dwin[r][2];
            end
            n_dwin[0][2] = b_older;
            n_dwin[1][2] = b_prev;
        end
        for (int r = 0; r < 3; r++) begin
            row_ok = (r == 0) ? r_s1_ctl.top : ((r == 1) ? 1'b1 : r_s1_ctl.bot);
            for (int c = 0; c < 3; c++) begin
                col_ok = (2'(c) >= r_s1_ctl.col_lo) && ((c != 2) || r_s1_ctl.col_hi);
                n_s2_mask[r * 3 + c] = row_ok && col_ok;
                if (r_s1_ctl.kind == CMD_DRAIN) begin
                    n_s2_vals[r * 3 + c] = n_dwin[(r == 0) ? 0 : 1][c];
                end else begin
                    n_s2_vals[r * 3 + c] = n_win[r][c];
                end
            end
        end
    end

    // pick the enabled tap whose rank equals half the enabled tap count, rounded down
    always_comb begin
        logic [RANK_W-1:0] cnt;
        logic [RANK_W-1:0] target;
        logic [RANK_W-1:0] rk;
        cnt = '0;
        med = '0;
        rk  = '0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            cnt = cnt + RANK_W'(r_s2_mask[i]);
        end
        target = cnt >> 1;
        for (int i = 0; i < NUM_TAPS; i++) begin
            rk = '0;
            for (int j = 0; j < NUM_TAPS; j++) begin
                if (r_s2_mask[j] && ((r_s2_vals[j] < r_s2_vals[i]) ||
                    ((r_s2_vals[j] == r_s2_vals[i]) && (j < i)))) begin
                    rk = rk + RANK_W'(1);
                end
            end
            if (r_s2_mask[i] && (rk == target)) begin
                med = med | r_s2_vals[i];
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.median_value = r_out_med;
    assign o_res.row_end      = r_out_row_end;
    assign o_res.frame_end    = r_out_frame_end;
    assign o_res.run_last     = r_out_run_last;

endmodule

// ===== src/median_filter_3x3_border_truncated.sv =====
// Streaming 3x3 median filter with the window cut back at the frame border.
// Pixels and flush ticks enter at up to one per clock while the command queue
// has room; a pixel closing a row after the first row yields two results, and
// the first flush tick of a frame also fetches column 0 of the line stores
// ahead of the drain. Each of these holds off the next item until its second
// command is queued. The single output port and the one read port per line
// store make this so. The line stores need no clearing pass.
// ----------------------------------------------------------------------------
// median_filter_3x3_border_truncated
// Top level: front classifier, command queue and median back end.
// ----------------------------------------------------------------------------
module median_filter_3x3_border_truncated
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mf3_in_if.sink                i_px,
    mf3_out_if.source             o_res
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CTL_W  = $bits(t_cmd_ctl);
    localparam int FIFO_W = CTL_W + AW + PIXEL_BITS;

    logic                  push;
    t_cmd_ctl              f_ctl;
    logic [AW-1:0]         f_addr;
    logic [PIXEL_BITS-1:0] f_pixel;
    logic                  full;
    logic                  empty;
    logic                  pop;
    logic [FIFO_W-1:0]     q_head;

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_px       (i_px),
        .i_full     (full),
        .o_push     (push),
        .o_ctl      (f_ctl),
        .o_addr     (f_addr),
        .o_pixel    (f_pixel)
    );

    mf3_cmd_fifo #(
        .DATA_W (FIFO_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_addr, f_pixel}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_head)
    );

    mf3_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_ctl   (t_cmd_ctl'(q_head[FIFO_W-1 -: CTL_W])),
        .i_addr  (q_head[PIXEL_BITS +: AW]),
        .i_pixel (q_head[PIXEL_BITS-1:0]),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== src/mf3_checker.sv =====
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_row_end,
    input logic i_out_frame_end,
    input logic i_out_run_last,
    input logic i_out_med_sign
);

    // a stalled transaction keeps its sign bit, row end and run end markers
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_med_sign)
            && $stable(i_out_row_end) && $stable(i_out_run_last))
        else $error("output changed while stalled");

    // frame end only on the last drain result of a row
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_frame_end |-> i_out_row_end && i_out_run_last)
        else $error("frame end without row end and run end");

    // the first of two results never closes a row
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_run_last |-> !i_out_row_end && !i_out_frame_end)
        else $error("row end on a non-final result");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind median_filter_3x3_border_truncated mf3_checker u_mf3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_row_end   (o_res.row_end),
    .i_out_frame_end (o_res.frame_end),
    .i_out_run_last  (o_res.run_last),
    .i_out_med_sign  (o_res.median_value[PIXEL_BITS-1])
);
